>>> rtl/flfq_pkg.sv
package flfq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned MEM_BYTES_DEF   = 65536;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned LAT_W      = 8;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned LINE_BYTES = 16;
  localparam int unsigned LINE_W     = LINE_BYTES * BYTE_W;
  localparam int unsigned MADDR_W    = 16;

  localparam logic [LAT_W-1:0] LATENCY_RESET = 8'd50;

  localparam logic CMD_TICK      = 1'b0;
  localparam logic CMD_MEM_WRITE = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic                squash;
    logic                line_consumed;
    logic                fetch_valid;
    logic [ADDR_W-1:0]   fetch_pc;
    logic [MADDR_W-1:0]  mem_addr;
    logic [BYTE_W-1:0]   mem_byte;
  } in_item_t;

  typedef struct packed {
    logic                line_ready;
    logic [ADDR_W-1:0]   line_addr;
    logic [WORD_W-1:0]   word_zero;
    logic [WORD_W-1:0]   word_one;
    logic [WORD_W-1:0]   word_two;
    logic [WORD_W-1:0]   word_three;
    logic                push_dropped;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD,
    ST_MEMWR,
    ST_FILL,
    ST_LINEWR,
    ST_HEADRD,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_adv;
    logic fill_start;
    logic mem_wr;
    logic fill_step;
    logic line_wr;
    logic head_rd;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_write;
    logic mask_empty;
    logic mask_hit;
    logic fill_last;
    logic out_busy;
  } dp_status_t;

endpackage

>>> rtl/flfq_stream_if.sv
interface flfq_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
  modport monitor (input valid, input ready, input payload);
endinterface

>>> rtl/flfq_ctrl.sv
module flfq_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output flfq_pkg::ctrl_cmd_t    cmd,
  input  flfq_pkg::dp_status_t   status
);

  flfq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= flfq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      flfq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = status.in_write ? flfq_pkg::ST_MEMWR : flfq_pkg::ST_SCAN;
        end
      end
      flfq_pkg::ST_SCAN: begin
        if (status.mask_empty) begin
          state_next = flfq_pkg::ST_HEADRD;
        end else if (status.mask_hit) begin
          state_next = flfq_pkg::ST_LOAD;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      flfq_pkg::ST_LOAD: begin
        cmd.fill_start = 1'b1;
        state_next     = flfq_pkg::ST_FILL;
      end
      flfq_pkg::ST_MEMWR: begin
        cmd.mem_wr = 1'b1;
        state_next = flfq_pkg::ST_HEADRD;
      end
      flfq_pkg::ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_last) begin
          state_next = flfq_pkg::ST_LINEWR;
        end
      end
      flfq_pkg::ST_LINEWR: begin
        cmd.line_wr = 1'b1;
        state_next  = flfq_pkg::ST_SCAN;
      end
      flfq_pkg::ST_HEADRD: begin
        cmd.head_rd = 1'b1;
        state_next  = flfq_pkg::ST_REPORT;
      end
      flfq_pkg::ST_REPORT: begin
        cmd.head_rd = 1'b1;
        // hold until the previous item has left the output register
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = flfq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = flfq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/flfq_datapath.sv
module flfq_datapath #(
  parameter int unsigned QUEUE_DEPTH = flfq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned MEM_BYTES   = flfq_pkg::MEM_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  flfq_pkg::ctrl_cmd_t               cmd,
  output flfq_pkg::dp_status_t              status,
  input  logic [flfq_pkg::LAT_W-1:0]        latency,
  input  flfq_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output flfq_pkg::out_item_t               out_item
);

  localparam int unsigned ADDR_W    = flfq_pkg::ADDR_W;
  localparam int unsigned LAT_W     = flfq_pkg::LAT_W;
  localparam int unsigned BYTE_W    = flfq_pkg::BYTE_W;
  localparam int unsigned WORD_W    = flfq_pkg::WORD_W;
  localparam int unsigned LINE_W    = flfq_pkg::LINE_W;
  localparam int unsigned IDX_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W     = CNT_W + 1;
  localparam int unsigned MA_W      = $clog2(MEM_BYTES);
  localparam int unsigned BC_W      = $clog2(flfq_pkg::LINE_BYTES + 1);

  localparam logic [MA_W-1:0]    MA_LAST   = MA_W'(MEM_BYTES - 1);
  localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]   DEPTH_C   = CNT_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0]   DEPTH_S   = SUM_W'(QUEUE_DEPTH);
  localparam logic [BC_W-1:0]    BYTES_C   = BC_W'(flfq_pkg::LINE_BYTES);

  // ring control state
  logic [QUEUE_DEPTH-1:0] valid;
  logic [QUEUE_DEPTH-1:0] fill_mask;
  logic [LAT_W-1:0]       countdown [QUEUE_DEPTH];
  logic [IDX_W-1:0]       head;
  logic [IDX_W-1:0]       scan;
  logic [CNT_W-1:0]       ring_count;
  logic                   dropped;

  // tick update
  logic [QUEUE_DEPTH-1:0] valid_next;
  logic [QUEUE_DEPTH-1:0] fill_mask_next;
  logic [LAT_W-1:0]       countdown_next [QUEUE_DEPTH];
  logic [IDX_W-1:0]       head_next;
  logic [CNT_W-1:0]       ring_count_next;
  logic                   pop;
  logic                   push;
  logic                   push_drop;
  logic [IDX_W-1:0]       push_slot;
  logic [CNT_W-1:0]       count_pop;
  logic [SUM_W-1:0]       slot_sum;
  logic [SUM_W-1:0]       slot_wrap;
  logic [LAT_W-1:0]       lat_eff;
  logic                   is_tick;

  // fill and memory path
  logic [BYTE_W-1:0]      item_byte;
  logic [IDX_W-1:0]       fill_slot;
  logic [ADDR_W-1:0]      mem_ptr;
  logic [ADDR_W-1:0]      fill_addr;
  logic [ADDR_W-1:0]      fill_addr_inc;
  logic [MA_W-1:0]        ma_next;
  logic [BC_W-1:0]        byte_cnt;
  logic [LINE_W-1:0]      line_acc;
  logic [BYTE_W-1:0]      mem_rd;
  logic [ADDR_W-1:0]      addr_rd;
  logic [LINE_W-1:0]      line_rd;
  logic [QUEUE_DEPTH-1:0] rdy_lane;
  logic                   head_ready;

  logic [BYTE_W-1:0]      backing_mem [MEM_BYTES];
  logic [ADDR_W-1:0]      addr_mem [QUEUE_DEPTH];
  logic [LINE_W-1:0]      line_mem [QUEUE_DEPTH];

  assign is_tick = (in_item.cmd == flfq_pkg::CMD_TICK);

  always_comb begin
    pop             = in_item.line_consumed && (ring_count != '0);
    head_next       = head;
    if (pop) begin
      head_next = (head == IDX_LAST) ? '0 : head + IDX_W'(1);
    end
    count_pop       = ring_count - CNT_W'(pop);
    push            = in_item.fetch_valid && (count_pop != DEPTH_C);
    push_drop       = in_item.fetch_valid && !push;
    slot_sum        = SUM_W'(head_next) + SUM_W'(count_pop);
    slot_wrap       = (slot_sum >= DEPTH_S) ? slot_sum - DEPTH_S : slot_sum;
    push_slot       = slot_wrap[IDX_W-1:0];
    ring_count_next = count_pop + CNT_W'(push);
    lat_eff         = (latency == '0) ? LAT_W'(1) : latency;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      valid_next[i]     = valid[i];
      countdown_next[i] = countdown[i];
      fill_mask_next[i] = 1'b0;
      if (push && (push_slot == IDX_W'(i))) begin
        valid_next[i]     = 1'b1;
        countdown_next[i] = lat_eff;
      end else if (pop && (head == IDX_W'(i))) begin
        valid_next[i]     = 1'b0;
        countdown_next[i] = '0;
      end else if (valid[i] && (countdown[i] != '0)) begin
        countdown_next[i] = countdown[i] - LAT_W'(1);
        fill_mask_next[i] = (countdown[i] == LAT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      fill_mask  <= '0;
      head       <= '0;
      scan       <= '0;
      ring_count <= '0;
      dropped    <= 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        countdown[i] <= '0;
      end
    end else if (cmd.accept) begin
      scan    <= '0;
      dropped <= 1'b0;
      if (is_tick) begin
        if (in_item.squash) begin
          valid      <= '0;
          fill_mask  <= '0;
          head       <= '0;
          ring_count <= '0;
          for (int i = 0; i < QUEUE_DEPTH; i++) begin
            countdown[i] <= '0;
          end
        end else begin
          valid      <= valid_next;
          fill_mask  <= fill_mask_next;
          head       <= head_next;
          ring_count <= ring_count_next;
          countdown  <= countdown_next;
          dropped    <= push_drop;
        end
      end
    end else begin
      if (cmd.scan_adv) begin
        scan <= scan + IDX_W'(1);
      end
      if (cmd.fill_start) begin
        fill_mask[scan] <= 1'b0;
      end
    end
  end

  // The user keeps MEM_BYTES a power of two; the block does not enforce it. Then the
  // low MA_W bits of an address give its byte. Step the byte address with a wrap at
  // MEM_BYTES, and restart at zero where the 32-bit address wraps.
  assign fill_addr_inc = fill_addr + ADDR_W'(1);
  assign ma_next = ((fill_addr_inc == '0) || (mem_ptr[MA_W-1:0] == MA_LAST)) ?
                   '0 : mem_ptr[MA_W-1:0] + MA_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_byte <= in_item.mem_byte;
      mem_ptr   <= ADDR_W'(in_item.mem_addr);
    end
    if (cmd.fill_start) begin
      fill_slot <= scan;
      mem_ptr   <= addr_rd;
      fill_addr <= addr_rd;
      byte_cnt  <= '0;
    end
    if (cmd.fill_step) begin
      if (byte_cnt != '0) begin
        line_acc <= {mem_rd, line_acc[LINE_W-1:BYTE_W]};
      end
      if (byte_cnt != BYTES_C) begin
        byte_cnt  <= byte_cnt + BC_W'(1);
        fill_addr <= fill_addr_inc;
        mem_ptr   <= ADDR_W'(ma_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      backing_mem[mem_ptr[MA_W-1:0]] <= item_byte;
    end
    mem_rd <= backing_mem[mem_ptr[MA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && is_tick && !in_item.squash && push) begin
      addr_mem[push_slot] <= in_item.fetch_pc;
    end
    addr_rd <= addr_mem[cmd.head_rd ? head : scan];
  end

  always_ff @(posedge clk) begin
    if (cmd.line_wr) begin
      line_mem[fill_slot] <= line_acc;
    end
    line_rd <= line_mem[head];
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      rdy_lane[i] = valid[i] && (countdown[i] == '0);
    end
  end

  assign head_ready = (ring_count != '0) && rdy_lane[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.line_ready   <= head_ready;
      out_item.line_addr    <= head_ready ? addr_rd : '0;
      out_item.word_zero    <= head_ready ? line_rd[0*WORD_W +: WORD_W] : '0;
      out_item.word_one     <= head_ready ? line_rd[1*WORD_W +: WORD_W] : '0;
      out_item.word_two     <= head_ready ? line_rd[2*WORD_W +: WORD_W] : '0;
      out_item.word_three   <= head_ready ? line_rd[3*WORD_W +: WORD_W] : '0;
      out_item.push_dropped <= dropped;
    end
  end

  assign status.in_write   = (in_item.cmd == flfq_pkg::CMD_MEM_WRITE);
  assign status.mask_empty = (fill_mask == '0);
  assign status.mask_hit   = fill_mask[scan];
  assign status.fill_last  = (byte_cnt == BYTES_C);
  assign status.out_busy   = out_valid && !out_ready;

endmodule

>>> rtl/fixed_latency_line_fetch_queue.sv
// Path: a memory-write item, or a tick that fills no line, goes from accept through
//   memory write or scan, head read and report; a tick adds scan hit, load, byte reads
//   and line write per line that fills, and a step per slot skipped, at most QUEUE_DEPTH - 1.
// Throughput: one item at a time; the next item is taken the cycle after the result is
//   registered, and a stalled result holds the following one back. MEM_BYTES: power of two.
// Reset: synchronous, clears the ring and the output valid and sets fetch_latency to 50.
module fixed_latency_line_fetch_queue #(
  parameter int unsigned QUEUE_DEPTH = flfq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned MEM_BYTES   = flfq_pkg::MEM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  flfq_stream_if.sink   req,
  flfq_stream_if.source rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_FETCH_LATENCY = 1'b0;

  logic [flfq_pkg::LAT_W-1:0] fetch_latency;
  logic                       cfg_wr;
  flfq_pkg::ctrl_cmd_t        cmd;
  flfq_pkg::dp_status_t       status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_latency <= flfq_pkg::LATENCY_RESET;
    end else if (cfg_wr && (paddr[2] == REG_FETCH_LATENCY)) begin
      fetch_latency <= pwdata[flfq_pkg::LAT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_FETCH_LATENCY) ? 32'(fetch_latency) : '0;

  flfq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .cmd      (cmd),
    .status   (status)
  );

  flfq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MEM_BYTES   (MEM_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .latency   (fetch_latency),
    .in_item   (req.payload),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_item  (rsp.payload)
  );

endmodule

>>> rtl/flfq_checker.sv
module flfq_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input flfq_pkg::out_item_t rsp_payload
);

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (req_ready && !rsp_valid))
    else $error("not idle after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("item taken while another is in work");

  a_empty_head_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_payload.line_ready) |->
      (rsp_payload.line_addr == '0 && rsp_payload.word_zero == '0 &&
       rsp_payload.word_one == '0 && rsp_payload.word_two == '0 &&
       rsp_payload.word_three == '0))
    else $error("line fields not cleared when head is not ready");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
    else $error("stalled result changed");

endmodule

bind fixed_latency_line_fetch_queue flfq_checker u_flfq_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);
